@@ src/g2ned_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// g2ned_pkg
// Shared constants, types and tables of the geodetic to local NED converter.
// ----------------------------------------------------------------------------
package g2ned_pkg;

  localparam int CORDIC_ITERATIONS = 30;
  localparam int CORDIC_N = (CORDIC_ITERATIONS > 40) ? 40 : CORDIC_ITERATIONS;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;
  localparam logic signed [33:0] HALF_TURN   = 34'sd2147483648;
  localparam logic signed [31:0] E2_Q30      = 32'sd7188036;
  localparam logic [63:0]        A_MM_Q30    = 64'd6378137000 << 30;
  localparam logic [31:0]        E7_TURN     = 32'd3600000000;
  localparam logic signed [47:0] SAT_HI      = 48'sd17179869183;
  localparam logic signed [47:0] SAT_LO      = -48'sd17179869184;

  // binary angle round(r * 2^32 / 3.6e9): estimate r + floor(r * ANG_RECIP / 2^33),
  // then add one when the remainder modulo ANG_DIV reaches ANG_DIV
  localparam logic signed [31:0] ANG_RECIP = 32'sd1658256560;  // floor(2^65/3.6e9) - 2^33
  localparam logic [23:0]        ANG_DIV   = 24'd3515625;      // 3.6e9 / 2^10
  localparam logic [23:0]        ANG_HALF  = 24'd1757812;      // floor(1.8e9 / 2^10)

  typedef struct packed {
    logic               start;
    logic               rnd;
    logic signed [47:0] d;
    logic signed [31:0] c;
  } mul_req_t;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_LATDIV = 10'b0000000010,
    S_LATCOR = 10'b0000000100,
    S_LONDIV = 10'b0000001000,
    S_LONCOR = 10'b0000010000,
    S_MUL    = 10'b0000100000,
    S_SQRT   = 10'b0001000000,
    S_NDIV   = 10'b0010000000,
    S_FIN    = 10'b0100000000,
    S_SPARE  = 10'b1000000000
  } state_t;

  typedef enum logic [3:0] {
    OP_S2   = 4'd0,
    OP_E2S2 = 4'd1,
    OP_T    = 4'd2,
    OP_X    = 4'd3,
    OP_Y    = 4'd4,
    OP_M    = 4'd5,
    OP_Z    = 4'd6,
    OP_UX   = 4'd7,
    OP_UY   = 4'd8,
    OP_EY   = 4'd9,
    OP_EX   = 4'd10,
    OP_NZ   = 4'd11,
    OP_NU   = 4'd12,
    OP_DU   = 4'd13,
    OP_DZ   = 4'd14
  } op_t;

  // atan(2^-i) in 2^-32 turn units
  function automatic logic [31:0] cordic_atan(input logic [5:0] i);
    logic [31:0] a;
    case (i)
      6'd0:  a = 32'd536870912;
      6'd1:  a = 32'd316933406;
      6'd2:  a = 32'd167458907;
      6'd3:  a = 32'd85004756;
      6'd4:  a = 32'd42667331;
      6'd5:  a = 32'd21354465;
      6'd6:  a = 32'd10679838;
      6'd7:  a = 32'd5340245;
      6'd8:  a = 32'd2670163;
      6'd9:  a = 32'd1335087;
      6'd10: a = 32'd667544;
      6'd11: a = 32'd333772;
      6'd12: a = 32'd166886;
      6'd13: a = 32'd83443;
      6'd14: a = 32'd41722;
      6'd15: a = 32'd20861;
      6'd16: a = 32'd10430;
      6'd17: a = 32'd5215;
      6'd18: a = 32'd2608;
      6'd19: a = 32'd1304;
      6'd20: a = 32'd652;
      6'd21: a = 32'd326;
      6'd22: a = 32'd163;
      6'd23: a = 32'd81;
      6'd24: a = 32'd41;
      6'd25: a = 32'd20;
      6'd26: a = 32'd10;
      6'd27: a = 32'd5;
      6'd28: a = 32'd3;
      6'd29: a = 32'd1;
      6'd30: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

  function automatic logic signed [34:0] sat35(input logic signed [47:0] v);
    logic signed [47:0] t;
    t = v;
    if (v > SAT_HI) t = SAT_HI;
    if (v < SAT_LO) t = SAT_LO;
    return t[34:0];
  endfunction

endpackage
`default_nettype wire

@@ src/geodetic_to_local_ned.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// geodetic_to_local_ned
// WGS84 geodetic fix to ECEF and to NED offsets from a captured reference.
// ----------------------------------------------------------------------------
// channel  dir  handshake              payload
// cfg      in   cfg_valid/cfg_ready    cfg_data: capture_time_ms
// s        in   s_tvalid/s_tready      s_tdata: fix fields
// m        out  m_tvalid/m_tready      m_tdata: ECEF and NED, m_tuser: flag
//
// A fix runs through two angle scalings (reciprocal product plus remainder
// fix), two CORDIC runs, a square root, a radius division and 7 Q30
// products, or 15 when a reference is held or is captured by that fix.
// s_tready is high only while idle; a finished result waits in the output
// register, and the next fix is taken as soon as that register is loaded.
// Reset clears the reference and sets capture_time_ms to 50000.
// ----------------------------------------------------------------------------
module geodetic_to_local_ned (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data,   // capture_time_ms
  input  logic         s_tvalid,
  output logic         s_tready,
  // elapsed_ms[31:0], latitude_e7[62:32], longitude_e7[94:63], height_mm[122:95]
  input  logic [127:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // ecef_x_mm[33:0], ecef_y_mm[67:34], ecef_z_mm[101:68], north_mm[136:102],
  // east_mm[171:137], down_mm[206:172]
  output logic [207:0] m_tdata,
  output logic [0:0]   m_tuser     // reference_valid
);
  import g2ned_pkg::*;

  state_t             state;
  op_t                op;
  logic               go;
  logic [31:0]        capture_time_ms;

  logic [31:0]        elapsed;
  logic signed [30:0] lat;
  logic signed [31:0] lon;
  logic signed [27:0] hgt;

  logic [31:0]        turn;
  logic signed [31:0] sb, cb, sl, cl;
  logic [30:0]        s2;
  logic [30:0]        w;
  logic [31:0]        r;
  logic signed [47:0] n;
  logic signed [47:0] t;
  logic signed [47:0] m;
  logic signed [33:0] x, y, z;
  logic signed [47:0] acc;
  logic signed [47:0] u;
  logic signed [34:0] north, east, down;

  logic               held;
  logic signed [31:0] ref_sin_lat, ref_cos_lat, ref_sin_lon, ref_cos_lon;
  logic signed [33:0] ref_ecef_x, ref_ecef_y, ref_ecef_z;

  logic signed [47:0] dx, dy, dz;
  logic signed [33:0] ang;
  logic signed [33:0] angw;
  logic               capture;

  logic [31:0]        ang_est;
  logic               ang_fix;
  logic [23:0]        ang_lo;
  logic [23:0]        ang_rem;
  logic [31:0]        ang_turn;

  mul_req_t           mreq;
  logic               mul_done;
  logic signed [47:0] mul_res;
  logic               div_start;
  logic [63:0]        div_dividend;
  logic [31:0]        div_divisor;
  logic               div_done;
  logic [63:0]        div_quot;
  logic               sq_start;
  logic               sq_done;
  logic [31:0]        sq_root;
  logic               cor_start;
  logic               cor_done;
  logic signed [31:0] cor_sin;
  logic signed [31:0] cor_cos;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);

  assign dx = 48'(x) - 48'(ref_ecef_x);
  assign dy = 48'(y) - 48'(ref_ecef_y);
  assign dz = 48'(z) - 48'(ref_ecef_z);

  assign capture = !held && (elapsed > capture_time_ms);

  // angle reduced into one turn of degrees*1e7
  assign ang  = (state == S_LATDIV) ? 34'(lat) : 34'(lon);
  assign angw = (ang < 0) ? ang + $signed({2'b00, E7_TURN}) : ang;

  // estimate is the quotient or one below; the low remainder bits decide
  assign ang_lo   = {angw[1:0], 22'd0} + ANG_HALF;
  assign ang_rem  = ang_lo - 24'(ang_est[23:0] * ANG_DIV);
  assign ang_turn = (ang_rem >= ANG_DIV) ? ang_est + 32'd1 : ang_est;

  assign div_start    = go && (state == S_NDIV);
  assign div_dividend = A_MM_Q30 + {33'd0, r[31:1]};
  assign div_divisor  = r;
  assign cor_start    = go && ((state == S_LATCOR) || (state == S_LONCOR));
  assign sq_start     = go && (state == S_SQRT);

  always_comb begin
    mreq.start = go && ((state == S_MUL) || (state == S_LATDIV) ||
                        (state == S_LONDIV));
    mreq.rnd   = 1'b1;
    mreq.d     = '0;
    mreq.c     = '0;
    if ((state == S_LATDIV) || (state == S_LONDIV)) begin
      mreq.d   = {16'd0, angw[31:0]};
      mreq.c   = ANG_RECIP;
      mreq.rnd = 1'b0;
    end else begin
      case (op)
        OP_S2:   begin mreq.d = 48'(sb); mreq.c = sb; end
        OP_E2S2: begin mreq.d = 48'(s2); mreq.c = E2_Q30; mreq.rnd = 1'b0; end
        OP_T:    begin mreq.d = n + 48'(hgt); mreq.c = cb; end
        OP_X:    begin mreq.d = t; mreq.c = cl; end
        OP_Y:    begin mreq.d = t; mreq.c = sl; end
        OP_M:    begin mreq.d = n; mreq.c = E2_Q30; end
        OP_Z:    begin mreq.d = n - m + 48'(hgt); mreq.c = sb; end
        OP_UX:   begin mreq.d = dx; mreq.c = ref_cos_lon; end
        OP_UY:   begin mreq.d = dy; mreq.c = ref_sin_lon; end
        OP_EY:   begin mreq.d = dy; mreq.c = ref_cos_lon; end
        OP_EX:   begin mreq.d = dx; mreq.c = ref_sin_lon; end
        OP_NZ:   begin mreq.d = dz; mreq.c = ref_cos_lat; end
        OP_NU:   begin mreq.d = u; mreq.c = ref_sin_lat; end
        OP_DU:   begin mreq.d = u; mreq.c = ref_cos_lat; end
        OP_DZ:   begin mreq.d = dz; mreq.c = ref_sin_lat; end
        default: ;
      endcase
    end
  end

  g2ned_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .done (mul_done),
    .res  (mul_res)
  );

  g2ned_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot)
  );

  g2ned_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .val   ({3'd0, w, 30'd0}),
    .done  (sq_done),
    .root  (sq_root)
  );

  g2ned_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .turn  (turn),
    .done  (cor_done),
    .sin_q (cor_sin),
    .cos_q (cor_cos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      op              <= OP_S2;
      go              <= 1'b0;
      ang_fix         <= 1'b0;
      capture_time_ms <= 32'd50000;
      held            <= 1'b0;
      ref_sin_lat     <= '0;
      ref_cos_lat     <= '0;
      ref_sin_lon     <= '0;
      ref_cos_lon     <= '0;
      ref_ecef_x      <= '0;
      ref_ecef_y      <= '0;
      ref_ecef_z      <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      go <= 1'b0;
      if (cfg_valid) capture_time_ms <= cfg_data;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            elapsed <= s_tdata[31:0];
            lat     <= s_tdata[62:32];
            lon     <= s_tdata[94:63];
            hgt     <= s_tdata[122:95];
            north   <= '0;
            east    <= '0;
            down    <= '0;
            go      <= 1'b1;
            state   <= S_LATDIV;
          end
        end
        S_LATDIV: begin
          if (mul_done) begin
            ang_est <= angw[31:0] + mul_res[34:3];
            ang_fix <= 1'b1;
          end else if (ang_fix) begin
            turn    <= ang_turn;
            ang_fix <= 1'b0;
            go      <= 1'b1;
            state   <= S_LATCOR;
          end
        end
        S_LATCOR: begin
          if (cor_done) begin
            sb    <= cor_sin;
            cb    <= cor_cos;
            go    <= 1'b1;
            state <= S_LONDIV;
          end
        end
        S_LONDIV: begin
          if (mul_done) begin
            ang_est <= angw[31:0] + mul_res[34:3];
            ang_fix <= 1'b1;
          end else if (ang_fix) begin
            turn    <= ang_turn;
            ang_fix <= 1'b0;
            go      <= 1'b1;
            state   <= S_LONCOR;
          end
        end
        S_LONCOR: begin
          if (cor_done) begin
            sl    <= cor_sin;
            cl    <= cor_cos;
            op    <= OP_S2;
            go    <= 1'b1;
            state <= S_MUL;
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            r     <= (sq_root == 32'd0) ? 32'd1 : sq_root;
            go    <= 1'b1;
            state <= S_NDIV;
          end
        end
        S_NDIV: begin
          if (div_done) begin
            n     <= 48'(div_quot[35:0]);
            op    <= OP_T;
            go    <= 1'b1;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_done) begin
            go <= 1'b1;
            op <= op_t'(op + 4'd1);
            case (op)
              OP_S2:   s2 <= (mul_res > 48'(ONE_Q30)) ? 31'(ONE_Q30) : mul_res[30:0];
              OP_E2S2: begin
                w     <= 31'(ONE_Q30) - mul_res[30:0];
                state <= S_SQRT;
              end
              OP_T:    t <= mul_res;
              OP_X:    x <= mul_res[33:0];
              OP_Y:    y <= mul_res[33:0];
              OP_M:    m <= mul_res;
              OP_Z: begin
                z <= mul_res[33:0];
                if (capture) begin
                  held        <= 1'b1;
                  ref_sin_lat <= sb;
                  ref_cos_lat <= cb;
                  ref_sin_lon <= sl;
                  ref_cos_lon <= cl;
                  ref_ecef_x  <= x;
                  ref_ecef_y  <= y;
                  ref_ecef_z  <= mul_res[33:0];
                end
                // offsets stay zero until a reference is held
                if (!(held || capture)) begin
                  go    <= 1'b0;
                  state <= S_FIN;
                end
              end
              OP_UX:   acc <= mul_res;
              OP_UY:   u <= acc + mul_res;
              OP_EY:   acc <= mul_res;
              OP_EX:   east <= sat35(acc - mul_res);
              OP_NZ:   acc <= mul_res;
              OP_NU:   north <= sat35(acc - mul_res);
              OP_DU:   acc <= -mul_res;
              OP_DZ: begin
                down  <= sat35(acc - mul_res);
                go    <= 1'b0;
                state <= S_FIN;
              end
              default: ;
            endcase
          end
        end
        S_FIN: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {1'b0, down, east, north, z, y, x};
            m_tuser  <= held;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ src/g2ned_mul.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// g2ned_mul
// Q30 product floor((d*c [+2^29]) / 2^30) from two 25x32 partial products.
// ----------------------------------------------------------------------------
module g2ned_mul (
  input  logic                clk,
  input  logic                rst,
  input  g2ned_pkg::mul_req_t req,
  output logic                done,
  output logic signed [47:0]  res
);
  import g2ned_pkg::*;

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_LO   = 4'b0010,
    M_HI   = 4'b0100,
    M_RND  = 4'b1000
  } mph_t;

  mph_t               ph;
  logic signed [47:0] d;
  logic signed [31:0] c;
  logic               rnd;
  logic signed [79:0] acc;
  logic signed [79:0] accr;
  logic signed [24:0] a;
  logic signed [56:0] prod;

  assign a    = (ph == M_LO) ? $signed({1'b0, d[23:0]}) : 25'($signed(d[47:24]));
  assign prod = a * c;
  assign accr = acc + (rnd ? 80'sd536870912 : 80'sd0);

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      ph <= M_IDLE;
    end else begin
      unique case (ph)
        M_IDLE: begin
          if (req.start) begin
            d   <= req.d;
            c   <= req.c;
            rnd <= req.rnd;
            ph  <= M_LO;
          end
        end
        M_LO: begin
          acc <= 80'(prod);
          ph  <= M_HI;
        end
        M_HI: begin
          acc <= acc + (80'(prod) <<< 24);
          ph  <= M_RND;
        end
        M_RND: begin
          res  <= accr[77:30];
          done <= 1'b1;
          ph   <= M_IDLE;
        end
        default: ph <= M_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ src/g2ned_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// g2ned_div
// Restoring unsigned divider, 64 by 32 bits, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module g2ned_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quot
);
  import g2ned_pkg::*;

  logic [31:0] rem;
  logic [31:0] dsr;
  logic [6:0]  cnt;
  logic        busy;
  logic [32:0] trial;
  logic        fits;

  assign trial = {rem, quot[63]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      quot <= dividend;
      dsr  <= divisor;
      rem  <= '0;
      cnt  <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      rem  <= fits ? 32'(trial - {1'b0, dsr}) : trial[31:0];
      quot <= {quot[62:0], fits};
      cnt  <= cnt + 7'd1;
      if (cnt == 7'd63) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/g2ned_sqrt.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// g2ned_sqrt
// Integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module g2ned_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] val,
  output logic        done,
  output logic [31:0] root
);
  import g2ned_pkg::*;

  logic [63:0] v;
  logic [63:0] acc;
  logic [63:0] bitm;
  logic        busy;
  logic [63:0] trial;

  assign trial = acc + bitm;
  assign root  = acc[31:0];

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      v    <= val;
      acc  <= '0;
      bitm <= 64'd1 << 62;
      busy <= 1'b1;
    end else if (busy) begin
      if (v >= trial) begin
        v   <= v - trial;
        acc <= (acc >> 1) + bitm;
      end else begin
        acc <= acc >> 1;
      end
      bitm <= bitm >> 2;
      if (bitm[0]) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/g2ned_cordic.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// g2ned_cordic
// Rotation-mode CORDIC: sine and cosine in Q2.30 of a 32-bit binary angle.
// ----------------------------------------------------------------------------
module g2ned_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        turn,
  output logic               done,
  output logic signed [31:0] sin_q,
  output logic signed [31:0] cos_q
);
  import g2ned_pkg::*;

  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [33:0] z;
  logic signed [33:0] zs;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [33:0] at;
  logic [5:0]         i;
  logic               flip;
  logic               busy;

  assign zs    = 34'($signed(turn));
  assign xs    = x >>> i;
  assign ys    = y >>> i;
  assign at    = $signed({2'b00, cordic_atan(i)});
  assign sin_q = 32'(flip ? -y : y);
  assign cos_q = 32'(flip ? -x : x);

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      // fold into +-90 degrees, negate results at the end
      if (zs > ONE_Q30) begin
        z    <= zs - HALF_TURN;
        flip <= 1'b1;
      end else if (zs < -ONE_Q30) begin
        z    <= zs + HALF_TURN;
        flip <= 1'b1;
      end else begin
        z    <= zs;
        flip <= 1'b0;
      end
      x    <= CORDIC_GAIN;
      y    <= '0;
      i    <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      if (z >= 0) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
      i <= i + 6'd1;
      if (i == 6'(CORDIC_N - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire
